/* hdl/rfsa_pkg.sv */
// types and constants shared by the rotating free-slot allocator
`default_nettype none

package rfsa_pkg;

   localparam int SLOT_W      = 6;
   localparam int UNIT_W      = 6;
   localparam int OWNER_W     = 32;
   localparam int OWNER_MAX_W = 64;
   localparam int CNT_W       = 7;

   localparam logic [CNT_W-1:0] SLOTS_RESET = 7'd64;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_ALLOC     = 2'd1,
      OP_SET_OWNER = 2'd2,
      OP_SET_OWNED = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [SLOT_W-1:0]   slot_index;
      logic [UNIT_W-1:0]   unit_id;
      logic                owned_value;
      logic [OWNER_W-1:0]  owner_id;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [SLOT_W-1:0]   found_slot;
      logic [UNIT_W-1:0]   found_unit;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/rotating_free_slot_allocator.sv */
// top level: slot count register, result register and the table sequencer
// path to rsp_valid: load via commit and emit; allocate via pointer wrap steps, scan
// (one table entry per cycle from the ram), commit and emit; updates via scan,
// commit and emit; early failures go straight to emit. One item at a time: the next
// is accepted once the result leaves the sequencer; a finished item waits in the output
// register; reset frees all slots, clears the rotating pointer, sets slot count to 64
`default_nettype none

module rotating_free_slot_allocator #(
   parameter int MAX_SLOTS  = 64,
   parameter int OWNER_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire rfsa_pkg::req_type           req_item,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rfsa_pkg::rsp_type                rsp_item,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [rfsa_pkg::CNT_W-1:0]  csr_data
);

   localparam int CW = rfsa_pkg::CNT_W;

   logic [CW-1:0]       slots_ff, slots_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rfsa_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   logic [CW-1:0]       slot_count;
   logic                eng_valid;
   logic                eng_ready;
   rfsa_pkg::rsp_type   eng_res;

   assign csr_ready  = 1'b1;
   assign slot_count = (slots_ff > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : slots_ff;
   assign eng_ready  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   rfsa_engine #(
      .MAX_SLOTS  (MAX_SLOTS),
      .OWNER_BITS (OWNER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .slot_count (slot_count),
      .item_valid (req_valid),
      .item_ready (req_ready),
      .item       (req_item),
      .res_valid  (eng_valid),
      .res_ready  (eng_ready),
      .res        (eng_res)
   );

   always_comb begin
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (csr_valid && csr_ready) begin
         slots_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= rfsa_pkg::SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while sequencer stays ready");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == rfsa_pkg::STATUS_FAIL
         |-> rsp_item.found_slot == '0 && rsp_item.found_unit == '0)
      else $error("failed item carries nonzero slot or unit");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

/* hdl/rfsa_ram.sv */
// generic single-port-write ram with one registered read port
`default_nettype none

module rfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/rfsa_engine.sv */
// slot table sequencer: ram scan, read-modify-write and pointer update
`default_nettype none

module rfsa_engine #(
   parameter int MAX_SLOTS  = 64,
   parameter int OWNER_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rfsa_pkg::CNT_W-1:0]  slot_count,
   input  wire logic                        item_valid,
   output logic                             item_ready,
   input  wire rfsa_pkg::req_type           item,
   output logic                             res_valid,
   input  wire logic                        res_ready,
   output rfsa_pkg::rsp_type                res
);

   localparam int AW        = $clog2(MAX_SLOTS);
   localparam int UW        = rfsa_pkg::UNIT_W;
   localparam int CW        = rfsa_pkg::CNT_W;
   localparam int EW        = OWNER_BITS + UW + 1;
   localparam int OWNED_POS = UW;
   localparam int OWNER_LSB = UW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SCAN,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   rfsa_pkg::req_type     item_ff, item_in;
   rfsa_pkg::rsp_type     res_ff, res_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic [AW-1:0]         hit_addr_ff, hit_addr_in;
   logic [AW-1:0]         rotate_ff, rotate_in;
   logic [CW-1:0]         issued_ff, issued_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  pend_ff, pend_in;
   logic                  vld_rd_ff, vld_rd_in;
   logic [EW-1:0]         entry_ff, entry_in;
   logic [MAX_SLOTS-1:0]  valid_ff, valid_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [EW-1:0]         rd_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   logic [rfsa_pkg::OWNER_MAX_W-1:0] owner_wide;
   logic [OWNER_BITS-1:0] owner_val;
   logic                  rd_owned;
   logic [UW-1:0]         rd_unit;
   logic                  is_alloc;
   logic                  match;
   logic [AW-1:0]         n_last;
   logic [CW-1:0]         ptr_next;

   rfsa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign item_ready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_EMIT);
   assign res        = res_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      addr_in      = addr_ff;
      pend_addr_in = pend_addr_ff;
      hit_addr_in  = hit_addr_ff;
      rotate_in    = rotate_ff;
      issued_in    = issued_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      vld_rd_in    = vld_rd_ff;
      entry_in     = entry_ff;
      valid_in     = valid_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_addr_ff;
      wr_data      = entry_ff;

      owner_wide = rfsa_pkg::OWNER_MAX_W'(item_ff.owner_id);
      owner_val  = owner_wide[OWNER_BITS-1:0];
      rd_owned   = vld_rd_ff & rd_data[OWNED_POS];
      rd_unit    = rd_data[UW-1:0];
      is_alloc   = (item_ff.opcode == rfsa_pkg::OP_ALLOC);
      match      = is_alloc ? !rd_owned : (rd_unit == item_ff.unit_id);
      n_last     = AW'(slot_count - CW'(1));
      ptr_next   = ptr_ff + CW'(1);

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in   = item;
               issued_in = '0;
               pend_in   = 1'b0;
               case (item.opcode)
                  rfsa_pkg::OP_LOAD: begin
                     if (CW'(item.slot_index) >= CW'(MAX_SLOTS)) begin
                        res_in        = '0;
                        res_in.status = rfsa_pkg::STATUS_FAIL;
                        state_in      = ST_EMIT;
                     end else begin
                        state_in = ST_COMMIT;
                     end
                  end
                  rfsa_pkg::OP_ALLOC: begin
                     if (slot_count == '0) begin
                        res_in        = '0;
                        res_in.status = rfsa_pkg::STATUS_FAIL;
                        state_in      = ST_EMIT;
                     end else begin
                        ptr_in   = CW'(rotate_ff);
                        state_in = ST_WRAP;
                     end
                  end
                  default: begin
                     addr_in  = '0;
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            // pointer modulo slot count, one subtract a cycle
            if (ptr_ff >= slot_count) begin
               ptr_in = ptr_ff - slot_count;
            end else begin
               addr_in  = AW'(slot_count - CW'(1) - ptr_ff);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff && match) begin
               hit_addr_in = pend_addr_ff;
               entry_in    = {rd_data[EW-1:OWNER_LSB], rd_owned, rd_unit};
               pend_in     = 1'b0;
               state_in    = ST_COMMIT;
            end else if (issued_ff == slot_count) begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_in        = '0;
                  res_in.status = rfsa_pkg::STATUS_FAIL;
                  state_in      = ST_EMIT;
               end
            end else begin
               rd_en        = 1'b1;
               vld_rd_in    = valid_ff[addr_ff];
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               issued_in    = issued_ff + CW'(1);
               if (is_alloc) begin
                  addr_in = (addr_ff == '0) ? n_last : addr_ff - AW'(1);
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         ST_COMMIT: begin
            res_in.status     = rfsa_pkg::STATUS_OK;
            res_in.found_slot = rfsa_pkg::SLOT_W'(hit_addr_ff);
            res_in.found_unit = entry_ff[UW-1:0];
            case (item_ff.opcode)
               rfsa_pkg::OP_LOAD: begin
                  wr_en             = 1'b1;
                  wr_addr           = item_ff.slot_index[AW-1:0];
                  wr_data           = {{OWNER_BITS{1'b1}}, item_ff.owned_value,
                                       item_ff.unit_id};
                  res_in.found_slot = item_ff.slot_index;
                  res_in.found_unit = item_ff.unit_id;
               end
               rfsa_pkg::OP_ALLOC: begin
                  rotate_in = (ptr_next == slot_count) ? '0 : AW'(ptr_next);
               end
               rfsa_pkg::OP_SET_OWNER: begin
                  wr_en   = 1'b1;
                  wr_data = {owner_val, entry_ff[OWNED_POS], entry_ff[UW-1:0]};
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_data = {entry_ff[EW-1:OWNER_LSB], item_ff.owned_value,
                             entry_ff[UW-1:0]};
               end
            endcase
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rotate_ff <= '0;
         valid_ff  <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rotate_ff <= rotate_in;
         valid_ff  <= valid_in;
         pend_ff   <= pend_in;
      end
      item_ff      <= item_in;
      res_ff       <= res_in;
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      hit_addr_ff  <= hit_addr_in;
      issued_ff    <= issued_in;
      ptr_ff       <= ptr_in;
      vld_rd_ff    <= vld_rd_in;
      entry_ff     <= entry_in;
   end

endmodule

`default_nettype wire
